// ===== rtl/core/morton3d_voxel_address_unit_defines.svh =====
// ----------------------------------------------------------------------------
// morton3d voxel address unit assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef MORTON3D_VOXEL_ADDRESS_UNIT_DEFINES_SVH
`define MORTON3D_VOXEL_ADDRESS_UNIT_DEFINES_SVH

// same-cycle implication, masked during reset
`define M3VA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, masked during reset
`define M3VA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// check that also holds during reset
`define M3VA_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/m3va_pkg.sv =====
// ----------------------------------------------------------------------------
// m3va_pkg
// shared types, constants and bit helpers of the morton voxel address unit
// ----------------------------------------------------------------------------
package m3va_pkg;

    localparam int COORD_BITS = 21;
    localparam int CODE_W     = 3 * COORD_BITS;
    localparam int BS_W       = 11;
    localparam int IDX_W      = 30;
    localparam int T1_W       = 2 * BS_W;
    localparam int DIV_STG    = COORD_BITS;
    localparam int NSTG       = DIV_STG + 3;
    localparam int NLANE      = 4;

    localparam logic [BS_W-1:0]       BS_RESET  = BS_W'(8);
    localparam logic [COORD_BITS-1:0] OFFS_BIAS = COORD_BITS'(1) << (COORD_BITS - 1);

    typedef logic [2:0] t_op;
    localparam t_op OP_ENCODE = 3'd0;
    localparam t_op OP_DECODE = 3'd1;
    localparam t_op OP_ADD    = 3'd2;
    localparam t_op OP_BASE   = 3'd3;
    localparam t_op OP_INDEX  = 3'd4;
    localparam t_op OP_LOCAL  = 3'd5;

    typedef logic [COORD_BITS-1:0] t_crd;

    // payload that travels beside the divider lanes
    typedef struct packed {
        t_op             op;
        t_crd            gx;
        t_crd            gy;
        t_crd            gz;
        t_crd            cx;
        t_crd            cy;
        t_crd            cz;
        logic [BS_W-1:0] b;
    } t_side;

    // place coordinate bit i at code bit 3i
    function automatic logic [CODE_W-1:0] spread(input t_crd v);
        logic [CODE_W-1:0] r;
        r = '0;
        for (int i = 0; i < COORD_BITS; i++) begin
            r[3*i] = v[i];
        end
        return r;
    endfunction

    // pick code bit 3i+sh as coordinate bit i
    function automatic t_crd gather(input logic [CODE_W-1:0] c, input int sh);
        t_crd r;
        r = '0;
        for (int i = 0; i < COORD_BITS; i++) begin
            r[i] = c[3*i+sh];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/m3va_div_lane.sv =====
// ----------------------------------------------------------------------------
// m3va_div_lane
// pipelined restoring remainder unit, one dividend bit per stage
// ----------------------------------------------------------------------------
module m3va_div_lane
    import m3va_pkg::*;
(
    input  logic               i_clk,
    input  logic [DIV_STG:0]   i_ld,
    input  t_crd               i_dvd,
    input  logic [BS_W-1:0]    i_div,
    output logic [BS_W-1:0]    o_rem
);

    logic [COORD_BITS-1:0] r_d [0:DIV_STG];
    logic [BS_W-1:0]       r_b [0:DIV_STG];
    logic [BS_W-1:0]       r_r [0:DIV_STG];
    logic [BS_W-1:0]       n_r [1:DIV_STG];
    logic [BS_W:0]         n_t [1:DIV_STG];

    // shift in the next dividend bit and subtract when it fits
    always_comb begin
        for (int k = 1; k <= DIV_STG; k++) begin
            n_t[k] = {r_r[k-1], r_d[k-1][COORD_BITS-1]};
            if (n_t[k] >= {1'b0, r_b[k-1]}) begin
                n_r[k] = BS_W'(n_t[k] - {1'b0, r_b[k-1]});
            end else begin
                n_r[k] = n_t[k][BS_W-1:0];
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_d[0] <= i_dvd;
            r_b[0] <= i_div;
            r_r[0] <= '0;
        end
        for (int k = 1; k <= DIV_STG; k++) begin
            if (i_ld[k]) begin
                r_d[k] <= r_d[k-1] << 1;
                r_b[k] <= r_b[k-1];
                r_r[k] <= n_r[k];
            end
        end
    end

    assign o_rem = r_r[DIV_STG];

endmodule

// ===== rtl/core/m3va_merge.sv =====
// ----------------------------------------------------------------------------
// m3va_merge
// combines lane remainders into codes, positions and the in-brick index
// ----------------------------------------------------------------------------
module m3va_merge
    import m3va_pkg::*;
(
    input  logic              i_clk,
    input  logic [1:0]        i_ld,
    input  t_side             i_side,
    input  logic [BS_W-1:0]   i_rx,
    input  logic [BS_W-1:0]   i_ry,
    input  logic [BS_W-1:0]   i_rz,
    input  logic [BS_W-1:0]   i_ro,
    output logic [CODE_W-1:0] o_code,
    output t_crd              o_pos_x,
    output t_crd              o_pos_y,
    output t_crd              o_pos_z,
    output logic [IDX_W-1:0]  o_idx
);

    logic [BS_W:0]       n_dx, n_dy, n_dz;
    logic [BS_W-1:0]     n_lx, n_ly, n_lz;
    t_crd                n_ux, n_uy, n_uz;
    logic [CODE_W-1:0]   n_code;
    t_crd                n_px, n_py, n_pz;
    logic [T1_W-1:0]     n_t1;
    logic [T1_W+BS_W:0]  n_sum;

    t_op                 r_op;
    logic [CODE_W-1:0]   r_code;
    t_crd                r_px, r_py, r_pz;
    logic [T1_W-1:0]     r_t1;
    logic [BS_W-1:0]     r_lx;
    logic [BS_W-1:0]     r_b;

    logic [CODE_W-1:0]   r_code_o;
    t_crd                r_px_o, r_py_o, r_pz_o;
    logic [IDX_W-1:0]    r_idx_o;

    // positive modulo: remainder of biased value minus remainder of bias
    always_comb begin
        n_dx = {1'b0, i_rx} - {1'b0, i_ro};
        n_dy = {1'b0, i_ry} - {1'b0, i_ro};
        n_dz = {1'b0, i_rz} - {1'b0, i_ro};
        n_lx = n_dx[BS_W] ? BS_W'(n_dx + {1'b0, i_side.b}) : n_dx[BS_W-1:0];
        n_ly = n_dy[BS_W] ? BS_W'(n_dy + {1'b0, i_side.b}) : n_dy[BS_W-1:0];
        n_lz = n_dz[BS_W] ? BS_W'(n_dz + {1'b0, i_side.b}) : n_dz[BS_W-1:0];
    end

    // biased coordinates to be interleaved
    always_comb begin
        n_ux = '0;
        n_uy = '0;
        n_uz = '0;
        case (i_side.op)
            OP_ENCODE: begin
                n_ux = i_side.cx ^ OFFS_BIAS;
                n_uy = i_side.cy ^ OFFS_BIAS;
                n_uz = i_side.cz ^ OFFS_BIAS;
            end
            OP_ADD: begin
                n_ux = i_side.gx + i_side.cx;
                n_uy = i_side.gy + i_side.cy;
                n_uz = i_side.gz + i_side.cz;
            end
            OP_BASE: begin
                n_ux = i_side.gx - COORD_BITS'(n_lx);
                n_uy = i_side.gy - COORD_BITS'(n_ly);
                n_uz = i_side.gz - COORD_BITS'(n_lz);
            end
            default: begin
                n_ux = '0;
            end
        endcase
        n_code = spread(n_ux) | (spread(n_uy) << 1) | (spread(n_uz) << 2);
    end

    // positions and first half of the index
    always_comb begin
        n_px = '0;
        n_py = '0;
        n_pz = '0;
        case (i_side.op)
            OP_DECODE: begin
                n_px = i_side.gx ^ OFFS_BIAS;
                n_py = i_side.gy ^ OFFS_BIAS;
                n_pz = i_side.gz ^ OFFS_BIAS;
            end
            OP_LOCAL: begin
                n_px = COORD_BITS'(n_lx);
                n_py = COORD_BITS'(n_ly);
                n_pz = COORD_BITS'(n_lz);
            end
            default: begin
                n_px = '0;
            end
        endcase
        n_t1 = ({{BS_W{1'b0}}, n_lz} * {{BS_W{1'b0}}, i_side.b})
             + {{BS_W{1'b0}}, n_ly};
    end

    // stage one: merged results
    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_op   <= i_side.op;
            r_code <= n_code;
            r_px   <= n_px;
            r_py   <= n_py;
            r_pz   <= n_pz;
            r_t1   <= n_t1;
            r_lx   <= n_lx;
            r_b    <= i_side.b;
        end
    end

    // second half of the index
    assign n_sum = ({{(BS_W+1){1'b0}}, r_t1} * {{(T1_W+1){1'b0}}, r_b})
                 + {{(T1_W+1){1'b0}}, r_lx};

    // stage two: output register
    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            r_code_o <= r_code;
            r_px_o   <= r_px;
            r_py_o   <= r_py;
            r_pz_o   <= r_pz;
            r_idx_o  <= (r_op == OP_INDEX) ? n_sum[IDX_W-1:0] : '0;
        end
    end

    assign o_code  = r_code_o;
    assign o_pos_x = r_px_o;
    assign o_pos_y = r_py_o;
    assign o_pos_z = r_pz_o;
    assign o_idx   = r_idx_o;

endmodule

// ===== rtl/core/morton3d_voxel_address_unit.sv =====
// ----------------------------------------------------------------------------
// morton3d_voxel_address_unit
// 3d morton code encode, decode, offset add and brick address operations
// ----------------------------------------------------------------------------
// Input items arrive on s_tvalid/s_tready with the op in s_tuser and the
// code and three coordinates in s_tdata; each item yields one result item on
// m_tvalid/m_tready carrying code, three positions and the in-brick index.
// The brick size register is written over the apb port at byte address 0.
// Throughput is one item per cycle while the receiver keeps m_tready high.
// An item passes the pipelined remainder lanes (one dividend bit per stage,
// four lanes: x, y, z and the coordinate bias), then the merge stage and
// then the index multiply and output register on its way to m_tvalid.
// Reset clears all valid flags and sets the brick size to 8.
// When the receiver stalls, the output item holds and empty stages keep
// filling, so up to 24 items are held in the pipe before s_tready drops.
// ----------------------------------------------------------------------------
module morton3d_voxel_address_unit
    import m3va_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // code_in[62:0], coord_x, coord_y, coord_z, pad
    input  logic [2:0]   s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // code_out, pos_x, pos_y, pos_z, brick_index, pad
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [BS_W-1:0]   r_bs;
    logic [NSTG-1:0]   r_vld;
    logic [NSTG-1:0]   n_rdy;
    t_side             r_side [0:DIV_STG];
    t_side             n_side;
    logic [BS_W-1:0]   n_rem [0:NLANE-1];
    t_crd              n_dvd [0:NLANE-1];
    logic [CODE_W-1:0] n_code;
    t_crd              n_px, n_py, n_pz;
    logic [IDX_W-1:0]  n_idx;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs <= BS_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_bs <= pwdata[BS_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-BS_W){1'b0}}, r_bs};

    // stage advance: a stage moves when empty or when the next one moves
    assign n_rdy[NSTG-1] = !r_vld[NSTG-1] || m_tready;
    generate
        for (genvar i = 0; i < NSTG - 1; i++) begin : g_rdy
            assign n_rdy[i] = !r_vld[i] || n_rdy[i+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_rdy[0]) begin
                r_vld[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (n_rdy[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    assign s_tready = n_rdy[0];
    assign m_tvalid = r_vld[NSTG-1];

    // split the incoming item
    always_comb begin
        n_side.op = s_tuser;
        n_side.gx = gather(s_tdata[CODE_W-1:0], 0);
        n_side.gy = gather(s_tdata[CODE_W-1:0], 1);
        n_side.gz = gather(s_tdata[CODE_W-1:0], 2);
        n_side.cx = s_tdata[83:63];
        n_side.cy = s_tdata[104:84];
        n_side.cz = s_tdata[125:105];
        n_side.b  = (r_bs == '0) ? BS_W'(1) : r_bs;
    end

    // side payload beside the lanes
    always_ff @(posedge i_clk) begin
        if (n_rdy[0]) begin
            r_side[0] <= n_side;
        end
        for (int k = 1; k <= DIV_STG; k++) begin
            if (n_rdy[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // remainder lanes: x, y, z and the bias
    assign n_dvd[0] = n_side.gx;
    assign n_dvd[1] = n_side.gy;
    assign n_dvd[2] = n_side.gz;
    assign n_dvd[3] = OFFS_BIAS;

    generate
        for (genvar l = 0; l < NLANE; l++) begin : g_lane
            m3va_div_lane u_lane (
                .i_clk (i_clk),
                .i_ld  (n_rdy[DIV_STG:0]),
                .i_dvd (n_dvd[l]),
                .i_div (n_side.b),
                .o_rem (n_rem[l])
            );
        end
    endgenerate

    m3va_merge u_merge (
        .i_clk   (i_clk),
        .i_ld    (n_rdy[NSTG-1:NSTG-2]),
        .i_side  (r_side[DIV_STG]),
        .i_rx    (n_rem[0]),
        .i_ry    (n_rem[1]),
        .i_rz    (n_rem[2]),
        .i_ro    (n_rem[3]),
        .o_code  (n_code),
        .o_pos_x (n_px),
        .o_pos_y (n_py),
        .o_pos_z (n_pz),
        .o_idx   (n_idx)
    );

    assign m_tdata = {4'd0, n_idx, n_pz, n_py, n_px, n_code};

endmodule

// ===== rtl/core/m3va_checker.sv =====
// ----------------------------------------------------------------------------
// m3va_checker
// port-level checks of the morton voxel address unit
// ----------------------------------------------------------------------------
`include "morton3d_voxel_address_unit_defines.svh"

module m3va_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata,
    input logic         pready
);

    // a stalled result item stays put
    `M3VA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // an empty output stage never blocks the input side
    `M3VA_ASSERT_NOW(a_in_free, i_clk, i_rst_n, !m_tvalid, s_tready)
    // reset leaves no result pending
    `M3VA_ASSERT_ALWAYS(a_rst_empty, i_clk, $past(!i_rst_n), !m_tvalid)
    // config port never waits
    `M3VA_ASSERT_ALWAYS(a_apb_ready, i_clk, 1'b1, pready)

endmodule

bind morton3d_voxel_address_unit m3va_checker u_m3va_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

// ===== dv/tb_morton3d_voxel_address_unit.sv =====
// ----------------------------------------------------------------------------
// tb_morton3d_voxel_address_unit
// self-checking bench: directed and random items over all ops and a set of brick sizes,
// each result compared field by field against a behavioral predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_morton3d_voxel_address_unit
    import m3va_pkg::*;
();

    localparam int OFFSET      = 1 << (COORD_BITS - 1);
    localparam int ADDR_BRICK  = 0;
    localparam int WDOG_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [IDX_W-1:0]      index;
        logic [COORD_BITS-1:0] pz;
        logic [COORD_BITS-1:0] py;
        logic [COORD_BITS-1:0] px;
        logic [CODE_W-1:0]     code;
    } t_voxel_res;

    // voxel address predictor and pending result store
    class voxel_scoreboard;
        t_voxel_res     pending[$];
        logic [BS_W-1:0] brick;
        int             errors;

        function new();
            brick = BS_RESET;
            errors = 0;
        endfunction

        function automatic longint ext21(logic [COORD_BITS-1:0] v);
            return longint'(signed'(v));
        endfunction

        function automatic logic [CODE_W-1:0] interleave(longint x, longint y, longint z);
            logic [CODE_W-1:0] c;
            logic [COORD_BITS-1:0] ux, uy, uz;
            ux = COORD_BITS'(x + OFFSET);
            uy = COORD_BITS'(y + OFFSET);
            uz = COORD_BITS'(z + OFFSET);
            c = '0;
            for (int i = 0; i < COORD_BITS; i++) begin
                c[3*i]   = ux[i];
                c[3*i+1] = uy[i];
                c[3*i+2] = uz[i];
            end
            return c;
        endfunction

        function automatic longint axis(logic [CODE_W-1:0] c, int sh);
            logic [COORD_BITS-1:0] r;
            for (int i = 0; i < COORD_BITS; i++) begin
                r[i] = c[3*i+sh];
            end
            return longint'({1'b0, r}) - OFFSET;
        endfunction

        function automatic longint fdiv(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0) begin
                q = q - 1;
            end
            return q;
        endfunction

        function automatic longint pmod(longint a, longint b);
            longint r;
            r = a % b;
            if (r < 0) begin
                r = r + b;
            end
            return r;
        endfunction

        function void note_item(t_op op, logic [CODE_W-1:0] c,
                                logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                                logic [COORD_BITS-1:0] cz);
            t_voxel_res r;
            longint p[3];
            longint b;
            b = (brick == 0) ? 1 : longint'(brick);
            for (int k = 0; k < 3; k++) begin
                p[k] = axis(c, k);
            end
            r = '0;
            case (op)
                OP_ENCODE: r.code = interleave(ext21(cx), ext21(cy), ext21(cz));
                OP_DECODE: begin
                    r.px = COORD_BITS'(p[0]);
                    r.py = COORD_BITS'(p[1]);
                    r.pz = COORD_BITS'(p[2]);
                end
                OP_ADD: r.code = interleave(p[0] + ext21(cx), p[1] + ext21(cy),
                                            p[2] + ext21(cz));
                OP_BASE: r.code = interleave(fdiv(p[0], b) * b, fdiv(p[1], b) * b,
                                             fdiv(p[2], b) * b);
                OP_INDEX: r.index = IDX_W'(pmod(p[2], b) * b * b + pmod(p[1], b) * b
                                           + pmod(p[0], b));
                OP_LOCAL: begin
                    r.px = COORD_BITS'(pmod(p[0], b));
                    r.py = COORD_BITS'(pmod(p[1], b));
                    r.pz = COORD_BITS'(pmod(p[2], b));
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(t_voxel_res got);
            t_voxel_res e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result item %h", got);
                end
                return;
            end
            e = pending.pop_front();
            if (got.code !== e.code || got.px !== e.px || got.py !== e.py ||
                got.pz !== e.pz || got.index !== e.index) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp code %h pos %h %h %h idx %h", e.code, e.px,
                             e.py, e.pz, e.index);
                    $display("          got code %h pos %h %h %h idx %h", got.code,
                             got.px, got.py, got.pz, got.index);
                end
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // code_in[62:0], coord_x, coord_y, coord_z, pad
    logic [2:0]   s_tuser;   // op
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;   // code_out, pos_x, pos_y, pos_z, brick_index, pad
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    voxel_scoreboard sb;
    bit  src_gaps;
    bit  sink_gaps;
    bit  sink_hold;
    int  idle_cycles;

    morton3d_voxel_address_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // accepted items go to the scoreboard at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) begin
            sb.note_item(s_tuser, s_tdata[62:0], s_tdata[83:63], s_tdata[104:84],
                         s_tdata[125:105]);
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            sb.check_result(t_voxel_res'(m_tdata[155:0]));
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, or a long hold on request
    initial begin
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold) begin
                m_tready <= 1'b0;
                repeat (200) @(negedge i_clk);
                sink_hold = 1'b0;
                m_tready <= 1'b1;
            end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 18);
                m_tready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // apb write of one register, setup phase then access phase
    task automatic reg_write(input int idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(4 * idx);
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == ADDR_BRICK) begin
            sb.brick = val[BS_W-1:0];
        end
    endtask

    // drive one item and wait for its handshake
    task automatic send_item(input t_op op, input logic [CODE_W-1:0] c,
                             input logic [COORD_BITS-1:0] x,
                             input logic [COORD_BITS-1:0] y,
                             input logic [COORD_BITS-1:0] z);
        int n;
        if (src_gaps && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b0, z, y, x, c};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // quiet input and wait for every result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    function automatic logic [CODE_W-1:0] rand_code();
        return CODE_W'({$urandom, $urandom});
    endfunction

    // random coordinate: mostly small near zero, sometimes full range
    function automatic logic [COORD_BITS-1:0] rand_crd();
        if ($urandom_range(0, 3) == 0) begin
            return COORD_BITS'($urandom);
        end
        return COORD_BITS'($urandom_range(0, 64) - 32);
    endfunction

    // code near the origin so brick ops cross sign boundaries
    function automatic logic [CODE_W-1:0] near_code();
        return sb.interleave(longint'(signed'(rand_crd())), longint'(signed'(rand_crd())),
                             longint'(signed'(rand_crd())));
    endfunction

    task automatic random_phase(input int count);
        t_op op;
        for (int i = 0; i < count; i++) begin
            op = t_op'($urandom_range(0, 7));
            send_item(op, $urandom_range(0, 1) ? rand_code() : near_code(),
                      rand_crd(), rand_crd(), rand_crd());
        end
    endtask

    localparam logic [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [CODE_W-1:0]     KALL = '1;

    initial begin
        logic [31:0] sizes[5];
        sb = new();
        sizes = '{32'd1, 32'd1024, 32'd0, 32'd2047, 32'd7};
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        sink_hold = 1'b0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes of each field, every op, undefined ops
        send_item(OP_ENCODE, '0, CMIN, CMIN, CMIN);
        send_item(OP_ENCODE, '0, CMAX, CMAX, CMAX);
        send_item(OP_ENCODE, KALL, '0, CMAX, CMIN);
        send_item(OP_DECODE, '0, '0, '0, '0);
        send_item(OP_DECODE, KALL, '0, '0, '0);
        send_item(OP_ADD, KALL, CMAX, CMAX, CMAX);
        send_item(OP_ADD, '0, CMIN, CMIN, CMIN);
        send_item(OP_BASE, '0, '0, '0, '0);
        send_item(OP_BASE, KALL, '0, '0, '0);
        send_item(OP_INDEX, KALL, '0, '0, '0);
        send_item(OP_INDEX, '0, '0, '0, '0);
        send_item(OP_LOCAL, '0, '0, '0, '0);
        send_item(OP_LOCAL, KALL, '0, '0, '0);
        send_item(3'd6, KALL, CMAX, CMAX, CMAX);
        send_item(3'd7, KALL, CMIN, CMIN, CMIN);
        drain();

        // random phases across brick sizes, extremes included
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
        foreach (sizes[k]) begin
            reg_write(ADDR_BRICK, sizes[k]);
            random_phase(250);
            if (k == 1) begin
                sink_hold = 1'b1;
                random_phase(60);
            end
            drain();
        end
        reg_write(ADDR_BRICK, 32'd8);
        random_phase(200);
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        random_phase(150);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/m3va_pkg.sv
rtl/core/m3va_div_lane.sv
rtl/core/m3va_merge.sv
rtl/core/morton3d_voxel_address_unit.sv
rtl/core/m3va_checker.sv
dv/tb_morton3d_voxel_address_unit.sv
